// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// trig at an edge implies cons at the same edge
`define ASSERT_IMPLIES(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cons)) \
        else $error(msg);

// trig at an edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/skvt_pkg.sv =====
package skvt_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int ENTRY_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PRESENT     = 2'd0,
        ST_ABSENT      = 2'd1,
        ST_FULL        = 2'd2,
        ST_CLEAR_EMPTY = 2'd3
    } status_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic descending;
        logic wr_value;
        logic grow;
        logic shrink;
    } cell_ctl_t;

endpackage

// ===== src/skvt_cell.sv =====
module skvt_cell import skvt_pkg::*; (
    input  logic                    aclk,
    input  cell_ctl_t               ctl,
    input  logic                    valid,
    input  logic signed [KEY_W-1:0] item_key,
    input  logic signed [VAL_W-1:0] item_value,
    input  logic                    reach_in,
    output logic                    reach_out,
    output logic                    hit,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic signed [VAL_W-1:0] right_value,
    output logic signed [KEY_W-1:0] key_q,
    output logic signed [VAL_W-1:0] value_q
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    le_reg;
    logic                    eq_reg;
    logic                    le_next;
    logic                    eq_next;
    logic                    stop;

    always_comb begin
        eq_next = valid && (key_reg == item_key);
        le_next = valid && (ctl.descending ? (key_reg >= item_key) : (key_reg <= item_key));
    end

    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            le_reg <= le_next;
            eq_reg <= eq_next;
        end
    end

    // scan reaches this cell only if every earlier cell passed without a match
    assign hit       = reach_in && eq_reg;
    assign stop      = reach_in && !le_reg;
    assign reach_out = reach_in && le_reg && !eq_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_value && hit) begin
            value_reg <= item_value;
        end
        if (ctl.grow) begin
            if (stop) begin
                key_reg   <= item_key;
                value_reg <= item_value;
            end else if (!reach_in) begin
                key_reg   <= left_key;
                value_reg <= left_value;
            end
        end
        if (ctl.shrink && (!reach_in || hit)) begin
            key_reg   <= right_key;
            value_reg <= right_value;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

// ===== src/sorted_key_value_table.sv =====
// Sorted key-value table built as a row of CAPACITY cells, one pair per cell, kept in
// ascending or descending key order (cfg register 0; register 1 is the value returned when
// nothing applies). Ops on s_tuser: insert, lookup, delete, clear. Every item gives one
// result. An item passes the compare state, which registers every cell's key compare in
// parallel, then the update state, which ripples the scan along the row, shifts cells for
// insert/delete and loads the output register, waiting while the output is held; the ripple
// across the row sets the clock limit. A new item can be taken in the update state once the
// output is free. Occupancy follows the entry count; no clearing pass after reset.
`include "assert_macros.svh"

module sorted_key_value_table import skvt_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // key, value
    input  logic [OP_W-1:0]      s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata    // result_value, status, entry_count, is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXE  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic                    descending_reg;
    logic signed [VAL_W-1:0] null_value_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    op_t                     op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    m_tvalid_reg;
    logic [39:0]             m_tdata_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    exe_go;
    logic                    any_hit;
    logic                    is_full;
    logic signed [VAL_W-1:0] found_value;
    logic signed [VAL_W-1:0] result_value;
    status_t                 status;
    cell_ctl_t               ctl;

    logic [CAPACITY:0]       reach;
    logic [CAPACITY-1:0]     hit_vec;
    logic signed [KEY_W-1:0] cell_key   [CAPACITY];
    logic signed [VAL_W-1:0] cell_value [CAPACITY];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_EXE) && out_free);
    assign in_fire  = s_tvalid && s_tready;
    assign exe_go   = (state_reg == S_EXE) && out_free;

    always_comb begin
        state_next = state_reg;
        if (in_fire) begin
            state_next = S_CMP;
        end else begin
            case (state_reg)
                S_IDLE:  state_next = S_IDLE;
                S_CMP:   state_next = S_EXE;
                S_EXE:   state_next = out_free ? S_IDLE : S_EXE;
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            descending_reg <= 1'b0;
            null_value_reg <= '1;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == 1'b0) begin
                    descending_reg <= cfg_data[0];
                end else begin
                    null_value_reg <= cfg_data;
                end
            end
            if (exe_go) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg    <= op_t'(s_tuser);
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
        if (exe_go) begin
            m_tdata_reg <= {count_next == '0, ENTRY_W'(count_next), status, result_value};
        end
    end

    assign is_full = (count_reg >= CNT_W'(CAPACITY));
    assign any_hit = |hit_vec;

    always_comb begin
        ctl.cmp_en     = (state_reg == S_CMP);
        ctl.descending = descending_reg;
        ctl.wr_value   = exe_go && (op_reg == OP_INSERT);
        ctl.grow       = exe_go && (op_reg == OP_INSERT) && !any_hit && !is_full;
        ctl.shrink     = exe_go && (op_reg == OP_DELETE) && any_hit;
    end

    always_comb begin
        found_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found_value = found_value | (hit_vec[i] ? cell_value[i] : '0);
        end
    end

    always_comb begin
        count_next   = count_reg;
        result_value = null_value_reg;
        status       = ST_ABSENT;
        case (op_reg)
            OP_CLEAR: begin
                count_next = '0;
                status     = (count_reg == '0) ? ST_CLEAR_EMPTY : ST_PRESENT;
            end
            OP_INSERT: begin
                if (any_hit) begin
                    result_value = found_value;
                    status       = ST_PRESENT;
                end else if (is_full) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (any_hit) begin
                    result_value = found_value;
                    status       = ST_PRESENT;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_LOOKUP: begin
                if (any_hit) begin
                    result_value = found_value;
                    status       = ST_PRESENT;
                end
            end
            default: status = ST_ABSENT;
        endcase
    end

    assign reach[0] = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] lk, rk;
        logic signed [VAL_W-1:0] lv, rv;

        if (g == 0) begin : g_first
            assign lk = key_reg;
            assign lv = value_reg;
        end else begin : g_mid_l
            assign lk = cell_key[g-1];
            assign lv = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign rk = key_reg;
            assign rv = value_reg;
        end else begin : g_mid_r
            assign rk = cell_key[g+1];
            assign rv = cell_value[g+1];
        end

        skvt_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .valid       (CNT_W'(g) < count_reg),
            .item_key    (key_reg),
            .item_value  (value_reg),
            .reach_in    (reach[g]),
            .reach_out   (reach[g+1]),
            .hit         (hit_vec[g]),
            .left_key    (lk),
            .left_value  (lv),
            .right_key   (rk),
            .right_value (rv),
            .key_q       (cell_key[g]),
            .value_q     (cell_value[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPLIES(a_single_hit, aclk, aresetn, state_reg == S_EXE, $onehot0(hit_vec), "more than one cell matched")
    `ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_accept_cmp, aclk, aresetn, in_fire, state_reg == S_CMP, "accepted item skipped compare")
    `ASSERT_IMPLIES(a_result_src, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == S_EXE), "result without update cycle")

endmodule
